/* rtl/smm_pkg.sv */
// Shared types, sizes and helpers of the square matrix multiply core.
// Used by smm_front, smm_queue, smm_back and square_matrix_multiply_core.
`default_nettype none

package smm_pkg;

   // Largest supported matrix dimension and derived sizes
   localparam int MAX_SIZE    = 8;
   localparam int DEPTH       = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int IDX_W       = $clog2(MAX_SIZE);
   localparam int SZ_W        = $clog2(MAX_SIZE + 1);
   localparam int POS_W       = $clog2(DEPTH + 1);

   // Field widths
   localparam int CFG_W       = 4;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int SUM_W       = 35;

   // Element queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(8);

   // Input item
   typedef struct packed {
      logic signed [ELEM_W-1:0] a_element;
      logic signed [ELEM_W-1:0] b_element;
      logic                     last_element;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [SUM_W-1:0] product_element;
      logic                    last_result;
   } rsp_type;

   // Classified element pair waiting to be stored
   typedef struct packed {
      logic [ADDR_W-1:0]        addr;
      logic signed [ELEM_W-1:0] a_element;
      logic signed [ELEM_W-1:0] b_element;
      logic                     last;
   } entry_type;

   // Effective dimension: zero counts as one, large values clamp to MAX_SIZE
   function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] size);
      logic [SZ_W-1:0] n;
      if (size == '0) begin
         n = SZ_W'(1);
      end else if (size > CFG_W'(MAX_SIZE)) begin
         n = SZ_W'(MAX_SIZE);
      end else begin
         n = SZ_W'(size);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/smm_front.sv */
// Front end: accepts element pairs and assigns each its store address.
// Depends on smm_pkg; feeds smm_queue.
`default_nettype none

module smm_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [smm_pkg::SZ_W-1:0]   size_n,
   input  wire logic                       req_valid,
   input  wire smm_pkg::req_type           req_data,
   output logic                            req_stall,
   input  wire logic                       q_full,
   output logic                            q_push,
   output smm_pkg::entry_type              q_entry
);

   logic [smm_pkg::POS_W-1:0] load_pos_ff;
   logic [smm_pkg::POS_W-1:0] load_pos_in;
   logic [smm_pkg::POS_W-1:0] total;
   logic [smm_pkg::POS_W-1:0] pos;
   logic [smm_pkg::POS_W-1:0] pos_next;

   // Back pressure comes straight from the queue
   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   // Position of this pair; a stale position restarts at zero
   always_comb begin
      total    = smm_pkg::POS_W'(size_n) * smm_pkg::POS_W'(size_n);
      pos      = (load_pos_ff >= total) ? '0 : load_pos_ff;
      pos_next = pos + smm_pkg::POS_W'(1);
      if (req_data.last_element || (pos_next >= total)) begin
         load_pos_in = '0;
      end else begin
         load_pos_in = pos_next;
      end
   end

   assign q_entry.addr      = pos[smm_pkg::ADDR_W-1:0];
   assign q_entry.a_element = req_data.a_element;
   assign q_entry.b_element = req_data.b_element;
   assign q_entry.last      = req_data.last_element;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
      end else if (q_push) begin
         load_pos_ff <= load_pos_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/smm_queue.sv */
// Short FIFO of classified element pairs between front and back.
// Depends on smm_pkg.
`default_nettype none

module smm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire smm_pkg::entry_type  entry_in,
   output logic                     full,
   input  wire logic                pop,
   output logic                     empty,
   output smm_pkg::entry_type       entry_out
);

   smm_pkg::entry_type               slot_ff [smm_pkg::QUEUE_DEPTH];
   logic [smm_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [smm_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [smm_pkg::QCNT_W-1:0]       count_ff;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == smm_pkg::QCNT_W'(smm_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign entry_out = slot_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == smm_pkg::QPTR_W'(smm_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + smm_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == smm_pkg::QPTR_W'(smm_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + smm_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + smm_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - smm_pkg::QCNT_W'(1);
         end
      end
   end

   // Storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/smm_back.sv */
// Back end: stores element pairs and runs the multiply-accumulate pipeline.
// Depends on smm_pkg; drains smm_queue and drives the result channel.
`default_nettype none

module smm_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [smm_pkg::SZ_W-1:0]   size_n,
   input  wire logic                       q_empty,
   input  wire smm_pkg::entry_type         q_entry,
   output logic                            q_pop,
   output logic                            rsp_valid,
   output smm_pkg::rsp_type                rsp_data,
   input  wire logic                       rsp_stall
);

   typedef enum logic {
      ST_LOAD,
      ST_COMPUTE
   } state_type;

   // Element stores
   logic signed [smm_pkg::ELEM_W-1:0] store_a [smm_pkg::DEPTH];
   logic signed [smm_pkg::ELEM_W-1:0] store_b [smm_pkg::DEPTH];

   // Sequencer
   state_type                    state_ff, state_in;
   logic [smm_pkg::IDX_W-1:0]    i_ff, i_in;
   logic [smm_pkg::IDX_W-1:0]    j_ff, j_in;
   logic [smm_pkg::IDX_W-1:0]    k_ff, k_in;
   logic [smm_pkg::ADDR_W-1:0]   row_base_ff, row_base_in;
   logic [smm_pkg::ADDR_W-1:0]   b_addr_ff, b_addr_in;
   logic [smm_pkg::ADDR_W-1:0]   a_addr;
   logic [smm_pkg::IDX_W-1:0]    nm1;

   // Pipeline
   logic                               advance;
   logic                               issue;
   logic signed [smm_pkg::ELEM_W-1:0]  a_rd_ff, b_rd_ff;
   logic                               s1_valid_ff, s1_valid_in;
   logic                               s1_klast_ff, s1_klast_in;
   logic                               s1_final_ff, s1_final_in;
   logic signed [smm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                               s2_valid_ff, s2_valid_in;
   logic                               s2_klast_ff, s2_klast_in;
   logic                               s2_final_ff, s2_final_in;
   logic signed [smm_pkg::SUM_W-1:0]   acc_ff, acc_in;
   logic signed [smm_pkg::SUM_W-1:0]   sum;
   logic                               rsp_valid_ff, rsp_valid_in;
   smm_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   assign nm1       = smm_pkg::IDX_W'(size_n - smm_pkg::SZ_W'(1));
   assign advance   = ~(rsp_valid_ff & rsp_stall);
   assign issue     = (state_ff == ST_COMPUTE) & advance;
   assign q_pop     = (state_ff == ST_LOAD) & ~q_empty;
   assign a_addr    = row_base_ff + smm_pkg::ADDR_W'(k_ff);
   assign sum       = acc_ff + smm_pkg::SUM_W'(prod_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state: loading pairs, then walking i, j, k over the product
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      row_base_in = row_base_ff;
      b_addr_in   = b_addr_ff;
      s1_valid_in = s1_valid_ff;
      s1_klast_in = s1_klast_ff;
      s1_final_in = s1_final_ff;
      s2_valid_in = s2_valid_ff;
      s2_klast_in = s2_klast_ff;
      s2_final_in = s2_final_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_LOAD: begin
            if (q_pop && q_entry.last) begin
               state_in    = ST_COMPUTE;
               i_in        = '0;
               j_in        = '0;
               k_in        = '0;
               row_base_in = '0;
               b_addr_in   = '0;
            end
         end
         ST_COMPUTE: begin
            if (advance) begin
               if (k_ff == nm1) begin
                  k_in = '0;
                  if (j_ff == nm1) begin
                     j_in      = '0;
                     b_addr_in = '0;
                     if (i_ff == nm1) begin
                        state_in = ST_LOAD;
                     end else begin
                        i_in        = i_ff + smm_pkg::IDX_W'(1);
                        row_base_in = row_base_ff + smm_pkg::ADDR_W'(size_n);
                     end
                  end else begin
                     j_in      = j_ff + smm_pkg::IDX_W'(1);
                     b_addr_in = smm_pkg::ADDR_W'(j_ff) + smm_pkg::ADDR_W'(1);
                  end
               end else begin
                  k_in      = k_ff + smm_pkg::IDX_W'(1);
                  b_addr_in = b_addr_ff + smm_pkg::ADDR_W'(size_n);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // Pipeline moves as a whole unless a finished result is held
      if (advance) begin
         s1_valid_in = issue;
         s1_klast_in = (k_ff == nm1);
         s1_final_in = (k_ff == nm1) && (j_ff == nm1) && (i_ff == nm1);
         s2_valid_in = s1_valid_ff;
         s2_klast_in = s1_klast_ff;
         s2_final_in = s1_final_ff;
         prod_in     = a_rd_ff * b_rd_ff;
         if (s2_valid_ff) begin
            if (s2_klast_ff) begin
               acc_in                      = '0;
               rsp_valid_in                = 1'b1;
               rsp_data_in.product_element = sum;
               rsp_data_in.last_result     = s2_final_ff;
            end else begin
               acc_in = sum;
            end
         end
      end
   end

   // State, counters, pipeline and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      row_base_ff <= row_base_in;
      b_addr_ff   <= b_addr_in;
      s1_klast_ff <= s1_klast_in;
      s1_final_ff <= s1_final_in;
      s2_klast_ff <= s2_klast_in;
      s2_final_ff <= s2_final_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Element stores: write from the queue, registered read for the MAC
   always_ff @(posedge clock) begin
      if (q_pop) begin
         store_a[q_entry.addr] <= q_entry.a_element;
         store_b[q_entry.addr] <= q_entry.b_element;
      end
      if (advance) begin
         a_rd_ff <= store_a[a_addr];
         b_rd_ff <= store_b[b_addr_ff];
      end
   end

endmodule

`default_nettype wire

/* rtl/square_matrix_multiply_core.sv */
// Square matrix multiply core, top level: size register, front, queue, back.
// Depends on smm_pkg, smm_front, smm_queue and smm_back.
//
// Usage: set the dimension n (1..8, 0 counts as 1, larger clamps to 8)
// through the csr_ port while the core is idle; it resets to 8. Then send
// n*n element pairs of A and B, row-major, on the req_ channel, flagging
// the final pair with last_element. The core returns the n*n elements of
// C = A*B on the rsp_ channel, row-major, the final one with last_result.
// Loading takes one pair per cycle unless req_stall is high; pairs pass a
// four-entry queue and are written into the stores at one per cycle while
// the back end loads. Then the multiply-accumulate pipeline issues one
// product term per cycle unless a held result stalls it: n*n*n terms for
// the matrix, one result per n terms, each term read from the stores,
// multiplied into the product register and accumulated for the result.
// req_stall rises once the queue is full, which happens while the pipeline
// runs. While a result is pending, rsp_stall freezes the whole pipeline
// with that result held stable. Reset is synchronous and clears the load
// position, queue and pipeline; element stores keep their contents.
`default_nettype none

module square_matrix_multiply_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire smm_pkg::req_type            req_data,
   output logic                             req_stall,
   output logic                             rsp_valid,
   output smm_pkg::rsp_type                 rsp_data,
   input  wire logic                        rsp_stall,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [smm_pkg::CFG_W-1:0]   csr_data
);

   logic [smm_pkg::CFG_W-1:0] size_ff;
   logic [smm_pkg::SZ_W-1:0]  size_n;
   logic                      q_push;
   logic                      q_pop;
   logic                      q_full;
   logic                      q_empty;
   smm_pkg::entry_type        q_in;
   smm_pkg::entry_type        q_out;

   // Size register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= smm_pkg::SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_data;
      end
   end

   assign size_n = smm_pkg::eff_size(size_ff);

   smm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .size_n    (size_n),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in)
   );

   smm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .entry_out (q_out)
   );

   smm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .size_n    (size_n),
      .q_empty   (q_empty),
      .q_entry   (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire
